// File: rtl/core/tga_rle_pkg.sv
// Shared types and constants for the run-length pixel decoder.
package tga_rle_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIM_W = 16;
  localparam int unsigned LIN_W = DIM_W + 1;
  localparam int unsigned ROW_SUM_W = DIM_W + 2;
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(LIN_W);
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ENABLE = 2'd2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] HEADER_REPEAT_BIT = 8'h80;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             alpha_enable;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
  } pixel_t;

endpackage

// File: rtl/core/tga_rle_pixel_decoder.sv
// Top level of the run-length pixel decoder: configuration registers and the two stages.
//
// The decoder takes one byte of run-length coded image data per cycle unless
// the divider or a stalled output holds it back, and emits one run per
// completed pixel, carrying its color, repeat count and start position; tlast
// marks the run that completes the image. A result passes the parser's pixel
// register and then the result register. When a run ends two or more rows
// past its start column (narrow images, or a position left outside a reduced
// geometry), the position unit resolves the wrap with a one-bit-per-cycle
// divider, and the input holds on that pixel meanwhile. Configuration writes
// are always ready and should be made while no transfer is in flight.
module tga_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [tga_rle_pkg::OUT_DATA_W-1:0] m_tdata,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_count,
  // [55:40] start_column, [71:56] start_row
  output logic        m_tlast,   // image_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data
);

  tga_rle_pkg::cfg_regs_t cfg;
  tga_rle_pkg::pixel_t    pix;
  logic                   pix_valid;
  logic                   pix_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= tga_rle_pkg::DIM_W'(1);
      cfg.image_height <= tga_rle_pkg::DIM_W'(1);
      cfg.alpha_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tga_rle_pkg::REG_IMAGE_WIDTH: cfg.image_width <= cfg_data;
        tga_rle_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        tga_rle_pkg::REG_ALPHA_ENABLE: cfg.alpha_enable <= cfg_data[0];
        default: cfg <= cfg;
      endcase
    end
  end

  tga_rle_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  tga_rle_position u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// File: rtl/core/tga_rle_parser.sv
// Packet header and pixel byte parser producing one pixel item per completed pixel.
module tga_rle_parser (
  input  logic                clk,
  input  logic                rst,
  input  tga_rle_pkg::cfg_regs_t cfg,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  output logic                pix_valid,
  input  logic                pix_ready,
  output tga_rle_pkg::pixel_t pix
);

  logic        expect_header;
  logic        run_packet;
  logic [7:0]  pixels_left;
  logic [1:0]  byte_in_pixel;
  logic [23:0] pixel_bytes;

  logic [1:0]  last_idx;
  logic [7:0]  left_fixed;
  logic [7:0]  left_next;
  logic [7:0]  count_next;
  logic        accept;
  logic        pix_done;

  assign s_tready = !pix_valid || pix_ready;
  assign accept = s_tvalid && s_tready;
  assign last_idx = cfg.alpha_enable ? 2'd3 : 2'd2;
  assign pix_done = accept && !expect_header && (byte_in_pixel >= last_idx);

  always_comb begin
    left_fixed = (pixels_left == 8'd0) ? 8'd1 : pixels_left;
    if (run_packet) begin
      count_next = left_fixed;
      left_next = 8'd0;
    end else begin
      count_next = 8'd1;
      left_next = left_fixed - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      run_packet <= 1'b0;
      pixels_left <= 8'd0;
      byte_in_pixel <= 2'd0;
      pixel_bytes <= 24'd0;
      pix_valid <= 1'b0;
    end else begin
      pix_valid <= pix_done || (pix_valid && !pix_ready);
      if (accept) begin
        if (expect_header) begin
          run_packet <= (s_tdata & tga_rle_pkg::HEADER_REPEAT_BIT) != 8'd0;
          pixels_left <= {1'b0, s_tdata[6:0]} + 8'd1;
          byte_in_pixel <= 2'd0;
          expect_header <= 1'b0;
        end else if (byte_in_pixel < last_idx) begin
          case (byte_in_pixel)
            2'd0: pixel_bytes[7:0] <= s_tdata;
            2'd1: pixel_bytes[15:8] <= s_tdata;
            2'd2: pixel_bytes[23:16] <= s_tdata;
            default: pixel_bytes <= pixel_bytes;
          endcase
          byte_in_pixel <= byte_in_pixel + 2'd1;
        end else begin
          pix.blue <= pixel_bytes[7:0];
          pix.green <= pixel_bytes[15:8];
          if (cfg.alpha_enable) begin
            pix.red <= pixel_bytes[23:16];
            pix.alpha <= s_tdata;
          end else begin
            pix.red <= s_tdata;
            pix.alpha <= tga_rle_pkg::ALPHA_OPAQUE;
          end
          pix.repeat_count <= count_next;
          byte_in_pixel <= 2'd0;
          pixels_left <= left_next;
          if (left_next == 8'd0) begin
            expect_header <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/tga_rle_position.sv
// Run position tracker with a serial divider for wide wraps, and the result register.
module tga_rle_position (
  input  logic                clk,
  input  logic                rst,
  input  tga_rle_pkg::cfg_regs_t cfg,
  input  logic                pix_valid,
  output logic                pix_ready,
  input  tga_rle_pkg::pixel_t pix,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [tga_rle_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                m_tlast
);

  typedef enum logic [1:0] {
    POS_IDLE,
    POS_DIV,
    POS_DONE
  } pos_state_t;

  pos_state_t state;

  logic [tga_rle_pkg::DIM_W-1:0]     column_pos;
  logic [tga_rle_pkg::DIM_W-1:0]     row_pos;
  logic [tga_rle_pkg::LIN_W-1:0]     div_dvd;
  logic [tga_rle_pkg::LIN_W-1:0]     div_quot;
  logic [tga_rle_pkg::DIM_W-1:0]     div_rem;
  logic [tga_rle_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [tga_rle_pkg::DIM_W-1:0]     w_eff;
  logic [tga_rle_pkg::DIM_W-1:0]     h_eff;
  logic [tga_rle_pkg::LIN_W-1:0]     lin;
  logic [tga_rle_pkg::LIN_W-1:0]     w_ext;
  logic                              fast;
  logic                              lin_ge_w;
  logic [tga_rle_pkg::LIN_W-1:0]     fast_col;
  logic [tga_rle_pkg::LIN_W-1:0]     quot_sel;
  logic [tga_rle_pkg::DIM_W-1:0]     col_sel;
  logic [tga_rle_pkg::ROW_SUM_W-1:0] row_sum;
  logic                              done;
  logic                              out_free;
  logic [tga_rle_pkg::LIN_W-1:0]     trial;
  logic                              trial_ge;

  assign w_eff = (cfg.image_width == '0) ? tga_rle_pkg::DIM_W'(1) : cfg.image_width;
  assign h_eff = (cfg.image_height == '0) ? tga_rle_pkg::DIM_W'(1) : cfg.image_height;
  assign w_ext = {1'b0, w_eff};
  assign lin = {1'b0, column_pos} + tga_rle_pkg::LIN_W'(pix.repeat_count);
  assign fast = lin < {w_eff, 1'b0};
  assign lin_ge_w = lin >= w_ext;
  assign fast_col = lin_ge_w ? (lin - w_ext) : lin;

  assign trial = {div_rem, div_dvd[tga_rle_pkg::LIN_W-1]};
  assign trial_ge = trial >= w_ext;

  always_comb begin
    if (state == POS_DONE) begin
      quot_sel = div_quot;
      col_sel = div_rem;
    end else begin
      quot_sel = tga_rle_pkg::LIN_W'(lin_ge_w);
      col_sel = fast_col[tga_rle_pkg::DIM_W-1:0];
    end
    row_sum = {2'b00, row_pos} + {1'b0, quot_sel};
    done = row_sum >= {2'b00, h_eff};
  end

  assign out_free = !m_tvalid || m_tready;
  assign pix_ready = out_free && ((state == POS_DONE) || ((state == POS_IDLE) && fast));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= POS_IDLE;
      column_pos <= '0;
      row_pos <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= (pix_valid && pix_ready) || (m_tvalid && !m_tready);
      case (state)
        POS_IDLE: begin
          if (pix_valid && !fast) begin
            div_dvd <= lin;
            div_quot <= '0;
            div_rem <= '0;
            div_cnt <= tga_rle_pkg::DIV_STEPS;
            state <= POS_DIV;
          end
        end
        POS_DIV: begin
          div_rem <= trial_ge ? tga_rle_pkg::DIM_W'(trial - w_ext)
                              : trial[tga_rle_pkg::DIM_W-1:0];
          div_quot <= {div_quot[tga_rle_pkg::LIN_W-2:0], trial_ge};
          div_dvd <= {div_dvd[tga_rle_pkg::LIN_W-2:0], 1'b0};
          div_cnt <= div_cnt - tga_rle_pkg::DIV_CNT_W'(1);
          if (div_cnt == tga_rle_pkg::DIV_CNT_W'(1)) begin
            state <= POS_DONE;
          end
        end
        POS_DONE: begin
          if (pix_valid && pix_ready) begin
            state <= POS_IDLE;
          end
        end
        default: state <= POS_IDLE;
      endcase
      if (pix_valid && pix_ready) begin
        m_tdata <= {row_pos, column_pos, pix.repeat_count, pix.alpha,
                    pix.blue, pix.green, pix.red};
        m_tlast <= done;
        if (done) begin
          column_pos <= '0;
          row_pos <= '0;
        end else begin
          column_pos <= col_sel;
          row_pos <= row_sum[tga_rle_pkg::DIM_W-1:0];
        end
      end
    end
  end

endmodule

// File: rtl/core/tga_rle_checker.sv
// Port-level checks on the decoder's result stream, bound to the top level.
module tga_rle_checker (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [tga_rle_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic m_tlast
);

  logic after_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      after_done <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      after_done <= m_tlast;
    end
  end

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid right after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled result changed.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[39:32] != 8'd0) && (m_tdata[39:32] <= 8'd128))
    else $error("Repeat count out of range.");

  a_new_image_origin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && after_done |-> m_tdata[71:40] == 32'd0)
    else $error("First run of an image does not start at the origin.");

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_checker (.*);

// File: bench/tga_rle_run_checker.sv
// Checker for the run-length pixel decoder: predicts each run from the byte stream and compares.
module tga_rle_run_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [7:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [tga_rle_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic m_tlast,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data,
  output int mismatches,
  output int runs_pending,
  output int runs_checked,
  output int images_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  count;
    logic [15:0] col;
    logic [15:0] row;
    logic        done;
  } run_t;

  logic [tga_rle_pkg::DIM_W-1:0] width_reg;
  logic [tga_rle_pkg::DIM_W-1:0] height_reg;
  logic             alpha_reg;

  bit          hdr_wait;
  bit          repeat_pkt;
  logic [7:0]  px_left;
  logic [1:0]  byte_idx;
  logic [23:0] px_bytes;
  logic [15:0] col_pos;
  logic [15:0] row_pos;

  run_t run_q[$];
  bit   run_bad;

  function automatic bit decode_byte(input logic [7:0] b, output run_t r);
    logic [1:0]  last_idx;
    logic [7:0]  cnt;
    int unsigned w;
    int unsigned h;
    int unsigned lin;
    int unsigned new_row;
    r = '0;
    if (hdr_wait) begin
      repeat_pkt = b[7];
      px_left = {1'b0, b[6:0]} + 8'd1;
      byte_idx = 2'd0;
      hdr_wait = 1'b0;
      return 1'b0;
    end
    last_idx = alpha_reg ? 2'd3 : 2'd2;
    if (byte_idx < last_idx) begin
      if (byte_idx != 2'd3) px_bytes[byte_idx*8 +: 8] = b;
      byte_idx = byte_idx + 2'd1;
      return 1'b0;
    end
    r.blue  = px_bytes[7:0];
    r.green = px_bytes[15:8];
    r.red   = alpha_reg ? px_bytes[23:16] : b;
    r.alpha = alpha_reg ? b : tga_rle_pkg::ALPHA_OPAQUE;
    byte_idx = 2'd0;
    if (px_left == 8'd0) px_left = 8'd1;
    if (repeat_pkt) begin
      cnt = px_left;
      px_left = 8'd0;
    end else begin
      cnt = 8'd1;
      px_left = px_left - 8'd1;
    end
    if (px_left == 8'd0) hdr_wait = 1'b1;
    w = (width_reg == '0) ? 1 : width_reg;
    h = (height_reg == '0) ? 1 : height_reg;
    lin = col_pos + cnt;
    new_row = row_pos + lin / w;
    r.count = cnt;
    r.col   = col_pos;
    r.row   = row_pos;
    r.done  = (new_row >= h);
    if (r.done) begin
      col_pos = '0;
      row_pos = '0;
    end else begin
      col_pos = 16'(lin % w);
      row_pos = 16'(new_row);
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      run_bad = 1'b1;
      $display("%0t: run %0d %s expected %0d actual %0d",
               $time, runs_checked, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    run_t got;
    run_t want;
    run_t pred;
    if (rst) begin
      width_reg  = 16'd1;
      height_reg = 16'd1;
      alpha_reg  = 1'b0;
      hdr_wait   = 1'b1;
      repeat_pkt = 1'b0;
      px_left    = '0;
      byte_idx   = '0;
      px_bytes   = '0;
      col_pos    = '0;
      row_pos    = '0;
      run_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.red   = m_tdata[7:0];
        got.green = m_tdata[15:8];
        got.blue  = m_tdata[23:16];
        got.alpha = m_tdata[31:24];
        got.count = m_tdata[39:32];
        got.col   = m_tdata[55:40];
        got.row   = m_tdata[71:56];
        got.done  = m_tlast;
        if (got.done) images_done++;
        if (run_q.size() == 0) begin
          mismatches++;
          $display("%0t: run %0d expected none actual %h", $time, runs_checked, got);
        end else begin
          want = run_q.pop_front();
          run_bad = 1'b0;
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("alpha", want.alpha, got.alpha);
          check_field("repeat_count", want.count, got.count);
          check_field("start_column", want.col, got.col);
          check_field("start_row", want.row, got.row);
          check_field("image_done", want.done, got.done);
          if (run_bad) mismatches++;
        end
        runs_checked++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tga_rle_pkg::REG_IMAGE_WIDTH: width_reg = cfg_data;
          tga_rle_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data;
          tga_rle_pkg::REG_ALPHA_ENABLE: alpha_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (decode_byte(s_tdata, pred)) run_q.push_back(pred);
      end
    end
    runs_pending <= run_q.size();
  end

endmodule

// File: bench/tga_rle_pixel_decoder_tb.sv
// Testbench top for the run-length pixel decoder: clock, reset, stimulus and verdict.
module tga_rle_pixel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tga_rle_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int BYTES_PER_SETTING = 66;
  localparam int SETTINGS_PER_PHASE = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [tga_rle_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tga_rle_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int runs_pending;
  int runs_checked;
  int images_done;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int bytes_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  bit cur_alpha = 1'b0;

  tga_rle_pixel_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tga_rle_run_checker u_run_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .runs_pending(runs_pending),
    .runs_checked(runs_checked), .images_done(images_done)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [tga_rle_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tga_rle_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_alpha(input bit a);
    write_reg(tga_rle_pkg::REG_ALPHA_ENABLE, {15'($urandom), a});
    cur_alpha = a;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_random_setting(input int k);
    logic [15:0] w;
    logic [15:0] h;
    settle();
    case ($urandom_range(9))
      0: w = 16'd0;
      1: w = 16'hFFFF;
      2: w = 16'd1;
      3, 4: w = 16'($urandom_range(2, 4));
      default: w = 16'($urandom_range(2, 20));
    endcase
    case ($urandom_range(9))
      0: h = 16'd0;
      1: h = 16'hFFFF;
      2: h = 16'd1;
      default: h = 16'($urandom_range(1, 12));
    endcase
    if (k == 2) begin
      w = 16'hFFFF;
      h = 16'hFFFF;
    end else if (k == 7) begin
      w = 16'd1;
      h = 16'hFFFF;
    end
    write_reg(tga_rle_pkg::REG_IMAGE_WIDTH, w);
    write_reg(tga_rle_pkg::REG_IMAGE_HEIGHT, h);
    write_alpha((k < 2) ? k[0] : 1'($urandom_range(1)));
    settings_used++;
  endtask

  task automatic send_packet();
    int n;
    int bpp;
    bpp = cur_alpha ? 4 : 3;
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(1, 5);
      repeat (n) send_byte(8'($urandom));
    end else if ($urandom_range(1) == 1) begin
      send_byte(tga_rle_pkg::HEADER_REPEAT_BIT | {1'b0, 7'($urandom)});
      repeat (bpp) send_byte(8'($urandom));
    end else begin
      n = ($urandom_range(19) == 0) ? $urandom_range(8, 32) : $urandom_range(1, 6);
      send_byte({1'b0, 7'(n - 1)});
      repeat (n * bpp) send_byte(8'($urandom));
    end
  endtask

  initial begin
    int start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 19;
    sink_idle_pct = 64;

    // A register value of zero behaves as one; the unused index is ignored.
    write_reg(tga_rle_pkg::REG_IMAGE_WIDTH, 16'd0);
    write_reg(tga_rle_pkg::REG_IMAGE_HEIGHT, 16'd0);
    write_reg(REG_UNUSED, 16'($urandom));
    // A long repeat overruns the one-pixel image, then literal pixels begin new images.
    send_byte(tga_rle_pkg::HEADER_REPEAT_BIT | 8'h7F);
    repeat (3) send_byte(8'h00);
    send_byte(8'h01);
    repeat (3) send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h3C);

    // Alpha mode switched off while a four-byte pixel is half read.
    settle();
    write_alpha(1'b1);
    send_byte(8'h00);
    send_byte(8'h11);
    send_byte(8'h22);
    settle();
    write_alpha(1'b0);
    send_byte(8'h33);

    // Alpha mode switched on while a three-byte pixel is half read.
    send_byte(8'h00);
    send_byte(8'h44);
    send_byte(8'h55);
    settle();
    write_alpha(1'b1);
    send_byte(8'h66);
    send_byte(8'h77);

    // A run spanning several rows, then a smaller geometry that leaves the position outside.
    settle();
    write_reg(tga_rle_pkg::REG_IMAGE_WIDTH, 16'd8);
    write_reg(tga_rle_pkg::REG_IMAGE_HEIGHT, 16'd8);
    send_byte(tga_rle_pkg::HEADER_REPEAT_BIT | 8'h13);
    repeat (4) send_byte(8'($urandom));
    settle();
    write_reg(tga_rle_pkg::REG_IMAGE_WIDTH, 16'd2);
    write_reg(tga_rle_pkg::REG_IMAGE_HEIGHT, 16'd2);
    send_byte(tga_rle_pkg::HEADER_REPEAT_BIT);
    repeat (4) send_byte(8'($urandom));

    for (int phase = 0; phase < 3; phase++) begin
      for (int k = 0; k < SETTINGS_PER_PHASE; k++) begin
        apply_random_setting(phase * SETTINGS_PER_PHASE + k);
        case (phase)
          0: begin
            src_idle_pct = 19;
            sink_idle_pct = 64;
          end
          1: begin
            src_idle_pct = 64;
            sink_idle_pct = 19;
          end
          default: begin
            src_idle_pct = 0;
            sink_idle_pct = 0;
          end
        endcase
        if (phase == 2 && k == 0) hold_request = 1'b1;
        start = bytes_sent;
        while (bytes_sent - start < BYTES_PER_SETTING) send_packet();
      end
    end

    settle();
    $display("Sent %0d bytes under %0d register settings and three idling patterns.",
             bytes_sent, settings_used);
    $display("Checked %0d runs, %0d of them closing an image.", runs_checked, images_done);
    if (mismatches == 0 && runs_pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/core/tga_rle_pkg.sv
rtl/core/tga_rle_parser.sv
rtl/core/tga_rle_position.sv
rtl/core/tga_rle_pixel_decoder.sv
rtl/core/tga_rle_checker.sv
bench/tga_rle_run_checker.sv
bench/tga_rle_pixel_decoder_tb.sv
